// File: design/b64d_pkg.sv
package b64d_pkg;

   // 6-bit symbol value offsets of the URL-safe alphabet
   localparam logic [5:0] LowerBase = 6'd26;
   localparam logic [5:0] DigitBase = 6'd52;
   localparam logic [5:0] DashValue = 6'd62;
   localparam logic [5:0] UnderValue = 6'd63;

   // ASCII codes bounding the alphabet ranges
   localparam logic [7:0] UpperFirst = 8'h41;
   localparam logic [7:0] UpperLast = 8'h5a;
   localparam logic [7:0] LowerFirst = 8'h61;
   localparam logic [7:0] LowerLast = 8'h7a;
   localparam logic [7:0] DigitFirst = 8'h30;
   localparam logic [7:0] DigitLast = 8'h39;
   localparam logic [7:0] DashChar = 8'h2d;
   localparam logic [7:0] UnderChar = 8'h5f;

   // Final status codes
   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_BAD_LENGTH = 2'd1,
      STATUS_BAD_CHAR = 2'd2,
      STATUS_LEFTOVER = 2'd3
   } status_type;

   // Pending bit counts (always even)
   localparam logic [2:0] Pending0 = 3'd0;
   localparam logic [2:0] Pending2 = 3'd2;
   localparam logic [2:0] Pending4 = 3'd4;
   localparam logic [2:0] Pending6 = 3'd6;

   // Length mod 4 value that makes a string invalid
   localparam logic [1:0] BadLengthMod = 2'd1;

   // Character lookup result
   typedef struct packed {
      logic       in_alphabet;
      logic [5:0] value;
   } symbol_type;

   // One result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       done_res;
      status_type status;
   } result_type;

endpackage

// File: design/b64d_if.sv
interface b64d_req_if;
   import b64d_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       last_char;

   modport source (output valid, output char_in, output last_char, input ready);
   modport sink (input valid, input char_in, input last_char, output ready);
endinterface

interface b64d_rsp_if;
   import b64d_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       done_res;
   logic [1:0] status;

   modport source (output valid, output out_byte, output byte_valid, output done_res,
                   output status, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input done_res,
                 input status, output ready);
endinterface

// File: design/b64d_map.sv
module b64d_map
   import b64d_pkg::*;
(
   input  logic [7:0] char_in,
   output symbol_type symbol
);

   // Translate one ASCII character into its 6-bit value
   always_comb begin
      symbol = '{in_alphabet: 1'b0, value: 6'd0};
      if (char_in >= UpperFirst && char_in <= UpperLast) begin
         symbol.in_alphabet = 1'b1;
         symbol.value = 6'(char_in - UpperFirst);
      end else if (char_in >= LowerFirst && char_in <= LowerLast) begin
         symbol.in_alphabet = 1'b1;
         symbol.value = 6'(char_in - LowerFirst) + LowerBase;
      end else if (char_in >= DigitFirst && char_in <= DigitLast) begin
         symbol.in_alphabet = 1'b1;
         symbol.value = 6'(char_in - DigitFirst) + DigitBase;
      end else if (char_in == DashChar) begin
         symbol.in_alphabet = 1'b1;
         symbol.value = DashValue;
      end else if (char_in == UnderChar) begin
         symbol.in_alphabet = 1'b1;
         symbol.value = UnderValue;
      end
   end

endmodule

// File: design/b64d_core.sv
module b64d_core
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] char_in,
   input  logic       last_char,
   output result_type result
);

   logic [5:0] pending_bits_ff, pending_bits_in;
   logic [2:0] pending_count_ff, pending_count_in;
   logic [1:0] length_mod_ff, length_mod_in;
   logic       bad_char_ff, bad_char_in;

   symbol_type symbol;
   logic [5:0] acc_bits;
   logic [2:0] acc_count;
   logic [7:0] byte_val;
   logic       byte_hit;
   logic       bad_any;
   status_type status_val;

   b64d_map u_map (
      .char_in (char_in),
      .symbol  (symbol)
   );

   // Merge the new symbol into the pending bits, peel off a byte when eight are ready
   always_comb begin
      acc_bits = pending_bits_ff;
      acc_count = pending_count_ff;
      byte_val = 8'd0;
      byte_hit = 1'b0;
      if (symbol.in_alphabet) begin
         case (pending_count_ff)
            Pending2: begin
               byte_val = {pending_bits_ff[1:0], symbol.value};
               byte_hit = 1'b1;
               acc_bits = 6'd0;
               acc_count = Pending0;
            end
            Pending4: begin
               byte_val = {pending_bits_ff[3:0], symbol.value[5:2]};
               byte_hit = 1'b1;
               acc_bits = {4'd0, symbol.value[1:0]};
               acc_count = Pending2;
            end
            Pending6: begin
               byte_val = {pending_bits_ff[5:0], symbol.value[5:4]};
               byte_hit = 1'b1;
               acc_bits = {2'd0, symbol.value[3:0]};
               acc_count = Pending4;
            end
            default: begin
               acc_bits = symbol.value;
               acc_count = Pending6;
            end
         endcase
      end
   end

   // Rank the final status: length, then bad character, then leftover bits
   always_comb begin
      length_mod_in = length_mod_ff + 2'd1;
      bad_any = bad_char_ff | ~symbol.in_alphabet;
      if (length_mod_in == BadLengthMod) begin
         status_val = STATUS_BAD_LENGTH;
      end else if (bad_any) begin
         status_val = STATUS_BAD_CHAR;
      end else if (acc_count != Pending0 && acc_bits != 6'd0) begin
         status_val = STATUS_LEFTOVER;
      end else begin
         status_val = STATUS_OK;
      end
   end

   // Clear the string state after its final character
   always_comb begin
      if (last_char) begin
         pending_bits_in = 6'd0;
         pending_count_in = Pending0;
         bad_char_in = 1'b0;
      end else begin
         pending_bits_in = acc_bits;
         pending_count_in = acc_count;
         bad_char_in = bad_any;
      end
   end

   always_comb begin
      result.out_byte = byte_val;
      result.byte_valid = byte_hit;
      result.done_res = last_char;
      result.status = last_char ? status_val : STATUS_OK;
   end

   // Advance string state once per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_bits_ff <= 6'd0;
         pending_count_ff <= Pending0;
         length_mod_ff <= 2'd0;
         bad_char_ff <= 1'b0;
      end else if (step) begin
         pending_bits_ff <= pending_bits_in;
         pending_count_ff <= pending_count_in;
         length_mod_ff <= last_char ? 2'd0 : length_mod_in;
         bad_char_ff <= bad_char_in;
      end
   end

endmodule

// File: design/base64url_strict_decoder.sv
// base64url strict decoder: one character of an unpadded URL-safe base64 string per beat
// on req_if, with last_char marking the string's final character; every beat gives one
// rsp_if beat carrying a decoded byte when that character completed one, and on the final
// character done_res with the status (ok, bad length, bad character, nonzero leftover
// bits). Bytes of a string whose status is not ok are still delivered and must be
// dropped by the consumer. A character goes through the input register and then the
// result register; one is accepted every cycle, limited only by rsp_if.ready, since
// each register holds one beat and the accumulator update is combinational.
module base64url_strict_decoder
   import b64d_pkg::*;
(
   input logic       clock,
   input logic       reset,
   b64d_req_if.sink  req_if,
   b64d_rsp_if.source rsp_if
);

   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_last_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       advance;

   // Move a beat from the input register to the result register when it is free
   assign advance = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   b64d_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .char_in   (in_char_ff),
      .last_char (in_last_ff),
      .result    (result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_char_ff <= req_if.char_in;
         in_last_ff <= req_if.last_char;
      end
   end

   // Result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.out_byte = out_ff.out_byte;
   assign rsp_if.byte_valid = out_ff.byte_valid;
   assign rsp_if.done_res = out_ff.done_res;
   assign rsp_if.status = out_ff.status;

endmodule

// File: design/b64d_checker.sv
module b64d_checker
   import b64d_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_done_res,
   input logic [1:0] rsp_status
);

   // Hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   // Drive a zero byte when no byte was completed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == 8'd0)
      else $error("byte present without byte_valid");

   // Report a status only on the final character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == STATUS_OK)
      else $error("status reported before the final character");

   // Accept input and hold no result beat right after reset
   assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready && !rsp_valid)
      else $error("block not empty after reset");

endmodule

bind base64url_strict_decoder b64d_checker u_b64d_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_out_byte   (rsp_if.out_byte),
   .rsp_byte_valid (rsp_if.byte_valid),
   .rsp_done_res   (rsp_if.done_res),
   .rsp_status     (rsp_if.status)
);
